FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset qualification; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every edge outside reset.
`define ITRD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ITRD_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ITRD_ASSERT(name, clk, rst_n, prop, msg)
`define ITRD_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers for the integer to radix digit converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itrd_pkg;

    localparam int VALUE_W       = 32;
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_LOW = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_Z_LOW = 7'h7a;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               is_signed;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new transaction
        logic out_sign;   // load '-' into the output register
        logic div_step;   // one restoring division bit
        logic push;       // store remainder as next digit
        logic pop;        // read back the most recent stored digit
        logic out_digit;  // load the popped digit into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic neg;        // leading minus required
        logic div_last;   // final bit of the current division
        logic quo_zero;   // quotient exhausted
        logic cnt_zero;   // no stored digits left
    } t_stat;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dd;
        dd = {1'b0, d};
        if (d < RADIX_DEC) begin
            return CHAR_ZERO + dd;
        end
        return CHAR_A_LOW + dd - {1'b0, RADIX_DEC};
    endfunction

endpackage

FILE: design/itrd_ram.sv
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/itrd_ctrl.sv
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: sign, digit extraction by repeated division, then readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itrd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  itrd_pkg::t_stat i_stat,
    output itrd_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    import itrd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_PUSH,
        S_READ,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;
    logic   w_out_load;

    // Output register can take a new character this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load      = i_in_valid;
            S_START: o_cmd.out_sign  = i_stat.neg && w_out_free;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_PUSH:  o_cmd.push      = 1'b1;
            S_READ:  o_cmd.pop       = 1'b1;
            S_EMIT:  o_cmd.out_digit = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    assign w_out_load = o_cmd.out_sign || o_cmd.out_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new character wins; otherwise drop the one just taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (!i_stat.neg || w_out_free) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_state <= i_stat.quo_zero ? S_READ : S_DIV;
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= i_stat.cnt_zero ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/itrd_dp.sv
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: magnitude, bit-serial divider, digit stack and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itrd_dp #(
    parameter int WORD_BITS = itrd_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  itrd_pkg::t_cmd      i_cmd,
    input  itrd_pkg::t_in_item  i_in_item,
    output itrd_pkg::t_stat     o_stat,
    output itrd_pkg::t_out_item o_out_item
);

    import itrd_pkg::*;

    localparam int AW = $clog2(WORD_BITS);
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int BW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] w_v;
    logic [WORD_BITS-1:0] w_mag;
    logic [RADIX_W-1:0]   w_radix;
    logic                 w_neg;

    logic [WORD_BITS-1:0] r_quo;
    logic [RADIX_W-1:0]   r_rem;
    logic [RADIX_W-1:0]   r_radix;
    logic                 r_neg;
    logic [BW-1:0]        r_bit_cnt;
    logic [CW-1:0]        r_dig_cnt;
    t_out_item            r_out;

    logic [RADIX_W:0]     w_trial;
    logic                 w_ge;
    logic [RADIX_W:0]     w_diff;
    logic [CW-1:0]        w_rd_cnt;
    logic [RADIX_W-1:0]   w_rd_digit;

    if (WORD_BITS <= VALUE_W) begin : g_trunc
        assign w_v = i_in_item.value[WORD_BITS-1:0];
    end else begin : g_ext
        assign w_v = {{(WORD_BITS - VALUE_W){1'b0}}, i_in_item.value};
    end

    always_comb begin
        w_radix = i_in_item.radix;
        if (i_in_item.radix < RADIX_MIN) begin
            w_radix = RADIX_MIN;
        end else if (i_in_item.radix > RADIX_MAX) begin
            w_radix = RADIX_MAX;
        end
    end

    // Minus sign only for signed decimal; magnitude negated modulo the word
    assign w_neg = i_in_item.is_signed && (w_radix == RADIX_DEC) && w_v[WORD_BITS-1];
    assign w_mag = w_neg ? ('0 - w_v) : w_v;

    // Restoring division step: shift in the next quotient bit
    assign w_trial = {r_rem, r_quo[WORD_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_radix});
    assign w_diff  = w_ge ? (w_trial - {1'b0, r_radix}) : w_trial;

    assign w_rd_cnt = r_dig_cnt - CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo     <= w_mag;
            r_rem     <= '0;
            r_radix   <= w_radix;
            r_neg     <= w_neg;
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo     <= {r_quo[WORD_BITS-2:0], w_ge};
            r_rem     <= w_diff[RADIX_W-1:0];
            r_bit_cnt <= r_bit_cnt + BW'(1);
        end
        if (i_cmd.push) begin
            r_rem     <= '0;
            r_bit_cnt <= '0;
            r_dig_cnt <= r_dig_cnt + CW'(1);
        end
        if (i_cmd.pop) begin
            r_dig_cnt <= w_rd_cnt;
        end
        if (i_cmd.out_sign) begin
            r_out.digit_char <= CHAR_MINUS;
            r_out.last       <= 1'b0;
        end
        if (i_cmd.out_digit) begin
            r_out.digit_char <= digit_to_ascii(w_rd_digit);
            r_out.last       <= (r_dig_cnt == '0);
        end
    end

    itrd_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (WORD_BITS)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_dig_cnt[AW-1:0]),
        .i_wr_data (r_rem),
        .i_rd_en   (i_cmd.pop),
        .i_rd_addr (w_rd_cnt[AW-1:0]),
        .o_rd_data (w_rd_digit)
    );

    assign o_stat.neg      = r_neg;
    assign o_stat.div_last = (r_bit_cnt == BW'(WORD_BITS - 1));
    assign o_stat.quo_zero = (r_quo == '0);
    assign o_stat.cnt_zero = (r_dig_cnt == '0);
    assign o_out_item      = r_out;

endmodule

FILE: design/integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a word to ASCII digits in radix 2..36, one character per output transfer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  input    in   i_in_valid / o_in_stall   i_in_item  (value, radix, is_signed)
//  output   out  o_out_valid / i_out_stall o_out_item (digit_char, last)
//
//  Each digit is extracted by the bit-serial divider and pushed to the digit
//  RAM, then read back from it in reverse order for output. One transaction
//  is in flight at a time.
//  Reset is synchronous, active low, and clears only the controller.
//  A stall on the output holds the character register and pauses readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_to_radix_digits_top #(
    parameter int WORD_BITS = itrd_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itrd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itrd_pkg::t_out_item o_out_item
);

    import itrd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    itrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    itrd_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

    `ITRD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input accepted but block not busy")
    `ITRD_ASSERT(a_char_legal, i_clk, i_rst_n, o_out_valid |-> (o_out_item.digit_char == CHAR_MINUS) || ((o_out_item.digit_char >= CHAR_ZERO) && (o_out_item.digit_char <= CHAR_NINE)) || ((o_out_item.digit_char >= CHAR_A_LOW) && (o_out_item.digit_char <= CHAR_Z_LOW)), "illegal output character")
    `ITRD_NEVER(a_minus_not_last, i_clk, i_rst_n, o_out_valid && o_out_item.last && (o_out_item.digit_char == CHAR_MINUS), "minus sign marked as last")
    `ITRD_NEVER(a_cmd_exclusive, i_clk, i_rst_n, w_cmd.out_sign && w_cmd.out_digit, "sign and digit loaded together")

endmodule
